/* rtl/dspt_pkg.sv */
// Shared constants, status type and arctangent table for the phase tracker.
package dspt_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int ANGLE_STEPS_DEF  = 16;
    localparam int PHASE_W          = 16;
    localparam int ANGLE_W          = 36;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;

    localparam logic signed [PHASE_W-1:0] PHASE_LIMIT = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANGLE_W-1:0] ROUND_HALF  = 36'sd65536;

    typedef struct packed {
        logic done;
        logic err;
    } dspt_lane_stat_t;

    // atan(2^-i) in Q30
    function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANGLE_W-1:0] a;
        begin
            case (idx)
                5'd0:    a = 36'sd843314857;
                5'd1:    a = 36'sd497837829;
                5'd2:    a = 36'sd263043837;
                5'd3:    a = 36'sd133525159;
                5'd4:    a = 36'sd67021687;
                5'd5:    a = 36'sd33543516;
                5'd6:    a = 36'sd16775851;
                5'd7:    a = 36'sd8388437;
                5'd8:    a = 36'sd4194283;
                5'd9:    a = 36'sd2097149;
                5'd10:   a = 36'sd1048576;
                5'd11:   a = 36'sd524288;
                5'd12:   a = 36'sd262144;
                5'd13:   a = 36'sd131072;
                5'd14:   a = 36'sd65536;
                5'd15:   a = 36'sd32768;
                5'd16:   a = 36'sd16384;
                5'd17:   a = 36'sd8192;
                5'd18:   a = 36'sd4096;
                5'd19:   a = 36'sd2048;
                5'd20:   a = 36'sd1024;
                5'd21:   a = 36'sd512;
                5'd22:   a = 36'sd256;
                5'd23:   a = 36'sd128;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

/* rtl/dual_slope_phase_tracker_unit.sv */
// Top level: sample history, two channel lanes and the merging output register.
//
//  channel   group                              fields (low bit first)
//  input     s_tvalid / s_tready / s_tdata      sample_time, first_value, second_value
//  output    m_tvalid / m_tready / m_tdata      first_slope, second_slope,
//            m_tuser                            first_phase, second_phase; step_error
//  config    cfg_wr_en / cfg_wr_data            use_time_step
//
// Each sample after the first passes through the bit-serial divider and the CORDIC loop
// in each lane; saturated or unit-step slopes skip the divider and a zero slope skips
// the CORDIC.
// Both lanes run in parallel; one sample is in flight at a time.
// The result waits in the output register; s_tready returns once the result is loaded.
// The very first sample after reset is stored and yields no result.
// Reset is asynchronous, active low, and sets use_time_step to 1.
module dual_slope_phase_tracker_unit #(
    parameter int SAMPLE_WIDTH = dspt_pkg::SAMPLE_WIDTH_DEF,
    parameter int ANGLE_STEPS  = dspt_pkg::ANGLE_STEPS_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               s_tvalid,
    output logic                                               s_tready,
    // sample_time, first_value, second_value
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]                s_tdata,
    output logic                                               m_tvalid,
    input  logic                                               m_tready,
    // first_slope, second_slope, first_phase, second_phase
    output logic [((2*SAMPLE_WIDTH+2*dspt_pkg::PHASE_W+7)/8)*8-1:0] m_tdata,
    // step_error
    output logic                                               m_tuser,
    input  logic                                               cfg_wr_en,
    input  logic                                               cfg_wr_data
);
    import dspt_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int OUT_W = ((2*W+2*PHASE_W+7)/8)*8;

    logic [W-1:0]          prev_time_reg;
    logic signed [W-1:0]   prev_first_reg, prev_second_reg;
    logic                  have_prev_reg, busy_reg, use_time_step_reg, m_tvalid_reg;
    logic                  err_reg;
    logic [2*W+2*PHASE_W-1:0] payload_reg;

    logic [W-1:0]          in_time;
    logic signed [W-1:0]   in_first, in_second;
    logic signed [W:0]     dt, d1, d2;
    logic                  accept, start, ack;
    dspt_lane_stat_t       stat1, stat2;
    logic signed [W-1:0]   slope1, slope2;
    logic signed [PHASE_W-1:0] phase1, phase2;

    assign in_time   = s_tdata[W-1:0];
    assign in_first  = s_tdata[2*W-1:W];
    assign in_second = s_tdata[3*W-1:2*W];
    assign dt        = $signed({1'b0, in_time}) - $signed({1'b0, prev_time_reg});
    assign d1        = (W+1)'(in_first) - (W+1)'(prev_first_reg);
    assign d2        = (W+1)'(in_second) - (W+1)'(prev_second_reg);

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && have_prev_reg;
    // merge: take both lanes once the output register is free
    assign ack      = stat1.done && stat2.done && (!m_tvalid_reg || m_tready);

    dspt_lane #(.SAMPLE_WIDTH(W), .ANGLE_STEPS(ANGLE_STEPS)) u_lane1 (
        .clk(clk), .rst_n(rst_n), .start(start), .ack(ack), .timed(use_time_step_reg),
        .diff(d1), .step(dt), .value(in_first),
        .stat(stat1), .slope(slope1), .phase(phase1)
    );

    dspt_lane #(.SAMPLE_WIDTH(W), .ANGLE_STEPS(ANGLE_STEPS)) u_lane2 (
        .clk(clk), .rst_n(rst_n), .start(start), .ack(ack), .timed(use_time_step_reg),
        .diff(d2), .step(dt), .value(in_second),
        .stat(stat2), .slope(slope2), .phase(phase2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg     <= '0;
            prev_first_reg    <= '0;
            prev_second_reg   <= '0;
            have_prev_reg     <= 1'b0;
            busy_reg          <= 1'b0;
            use_time_step_reg <= 1'b1;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                use_time_step_reg <= cfg_wr_data;
            if (accept)
            begin
                prev_time_reg   <= in_time;
                prev_first_reg  <= in_first;
                prev_second_reg <= in_second;
                have_prev_reg   <= 1'b1;
            end
            if (start)
                busy_reg <= 1'b1;
            else if (ack)
                busy_reg <= 1'b0;
            if (ack)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            payload_reg <= {phase2, phase1, slope2, slope1};
            err_reg     <= stat1.err | stat2.err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(payload_reg);
    assign m_tuser  = err_reg;

endmodule

/* rtl/dspt_lane.sv */
// One channel lane: restoring divider for the slope, then vectoring CORDIC for the phase.
module dspt_lane #(
    parameter int SAMPLE_WIDTH = dspt_pkg::SAMPLE_WIDTH_DEF,
    parameter int ANGLE_STEPS  = dspt_pkg::ANGLE_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 ack,
    input  logic                                 timed,
    input  logic signed [SAMPLE_WIDTH:0]         diff,
    input  logic signed [SAMPLE_WIDTH:0]         step,
    input  logic signed [SAMPLE_WIDTH-1:0]       value,
    output dspt_pkg::dspt_lane_stat_t            stat,
    output logic signed [SAMPLE_WIDTH-1:0]       slope,
    output logic signed [dspt_pkg::PHASE_W-1:0]  phase
);
    import dspt_pkg::*;

    localparam int W   = SAMPLE_WIDTH;
    localparam int XW  = W + 3;
    localparam int OW  = 2 * W - 15;
    localparam int DCW = $clog2(W);
    localparam int ACW = $clog2(ANGLE_STEPS);
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_SIGN = 7'b0000100,
        ST_PREP = 7'b0001000,
        ST_ROT  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_DONE = 7'b1000000
    } lane_state_t;

    lane_state_t                 state_reg, state_next;
    logic [DCW-1:0]              dcnt_reg, dcnt_next;
    logic [ACW-1:0]              acnt_reg, acnt_next;
    logic                        err_reg, err_next;

    logic [W+1:0]                rem_reg, rem_next;
    logic [W-1:0]                dlow_reg, dlow_next;
    logic [W-1:0]                quo_reg, quo_next;
    logic [W:0]                  den_reg, den_next;
    logic                        neg_reg, neg_next;
    logic signed [W-1:0]         slope_reg, slope_next;
    logic signed [W-1:0]         value_reg, value_next;
    logic signed [XW-1:0]        x_reg, x_next;
    logic signed [XW-1:0]        y_reg, y_next;
    logic signed [ANGLE_W-1:0]   z_reg, z_next;
    logic signed [PHASE_W-1:0]   phase_reg, phase_next;

    logic [W:0]                  num_abs, den_abs;
    logic                        ovf;
    logic [W+1:0]                trial;
    logic signed [XW-1:0]        sx, sy, xs, ys;
    logic signed [ANGLE_W-1:0]   zr, qz;

    always_comb
    begin
        num_abs = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
        den_abs = step[W] ? (W+1)'(-step) : (W+1)'(step);
        ovf     = OW'(num_abs) >= (OW'(den_abs) << (W - 16));
        trial   = {rem_reg[W:0], dlow_reg[W-1]};
        sx      = x_reg >>> acnt_reg;
        sy      = y_reg >>> acnt_reg;
        xs      = XW'(value_reg);
        ys      = XW'(slope_reg);
        zr      = z_reg + ROUND_HALF;
        qz      = zr >>> 17;

        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        acnt_next  = acnt_reg;
        err_next   = err_reg;
        rem_next   = rem_reg;
        dlow_next  = dlow_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        slope_next = slope_reg;
        value_next = value_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        phase_next = phase_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = value;
                    err_next   = 1'b0;
                    neg_next   = diff[W] ^ step[W];
                    den_next   = den_abs;
                    rem_next   = (W+2)'(num_abs >> (W - 16));
                    dlow_next  = W'({num_abs, 16'b0});
                    dcnt_next  = '0;
                    state_next = ST_PREP;
                    if (!timed)
                    begin
                        if (diff[W] != diff[W-1])
                            slope_next = diff[W] ? SMIN : SMAX;
                        else
                            slope_next = diff[W-1:0];
                    end
                    else if (step == '0)
                    begin
                        err_next = 1'b1;
                        if (diff == '0)
                            slope_next = '0;
                        else
                            slope_next = diff[W] ? SMIN : SMAX;
                    end
                    else if (ovf)
                        slope_next = (diff[W] ^ step[W]) ? SMIN : SMAX;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= (W+2)'(den_reg))
                begin
                    rem_next = trial - (W+2)'(den_reg);
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                dlow_next = dlow_reg << 1;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(W - 1))
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                if (neg_reg)
                    slope_next = (quo_reg > {1'b1, {(W-1){1'b0}}}) ? SMIN : -quo_reg;
                else
                    slope_next = (quo_reg > SMAX) ? SMAX : quo_reg;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                acnt_next = '0;
                if (slope_reg == '0)
                begin
                    phase_next = value_reg[W-1] ? PHASE_LIMIT : '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ROT;
                    if (value_reg[W-1])
                    begin
                        z_next = slope_reg[W-1] ? -PI_Q30 : PI_Q30;
                        x_next = -xs;
                        y_next = -ys;
                    end
                    else
                    begin
                        z_next = '0;
                        x_next = xs;
                        y_next = ys;
                    end
                end
            end
            ST_ROT:
            begin
                if (!y_reg[XW-1])
                begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + atan_q30(ATAN_IDX_W'(acnt_reg));
                end
                else
                begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - atan_q30(ATAN_IDX_W'(acnt_reg));
                end
                acnt_next = acnt_reg + 1'b1;
                if (acnt_reg == ACW'(ANGLE_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // round Q30 to Q3.13, then clamp to +-pi
                if (qz > ANGLE_W'(PHASE_LIMIT))
                    phase_next = PHASE_LIMIT;
                else if (qz < -ANGLE_W'(PHASE_LIMIT))
                    phase_next = -PHASE_LIMIT;
                else
                    phase_next = qz[PHASE_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ack)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dcnt_reg  <= '0;
            acnt_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            acnt_reg  <= acnt_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dlow_reg  <= dlow_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        slope_reg <= slope_next;
        value_reg <= value_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        phase_reg <= phase_next;
    end

    assign stat.done = (state_reg == ST_DONE);
    assign stat.err  = err_reg;
    assign slope     = slope_reg;
    assign phase     = phase_reg;

endmodule

/* rtl/dspt_checker.sv */
// Port-level checker for the phase tracker, bound to the top level.
module dspt_checker #(
    parameter int SAMPLE_WIDTH = dspt_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                                    clk,
    input logic                                                    rst_n,
    input logic                                                    s_tvalid,
    input logic                                                    s_tready,
    input logic                                                    m_tvalid,
    input logic                                                    m_tready,
    input logic [((2*SAMPLE_WIDTH+2*dspt_pkg::PHASE_W+7)/8)*8-1:0] m_tdata,
    input logic                                                    m_tuser
);
    import dspt_pkg::*;

    localparam int W = SAMPLE_WIDTH;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0]       slope1;
    logic signed [PHASE_W-1:0] ph1, ph2;

    assign slope1 = m_tdata[W-1:0];
    assign ph1    = m_tdata[2*W+PHASE_W-1:2*W];
    assign ph2    = m_tdata[2*W+2*PHASE_W-1:2*W+PHASE_W];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too soon after a request");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ph1 <= PHASE_LIMIT && ph1 >= -PHASE_LIMIT
                  && ph2 <= PHASE_LIMIT && ph2 >= -PHASE_LIMIT)
        else $error("phase out of range");

    a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> slope1 == SMAX || slope1 == SMIN || slope1 == '0)
        else $error("zero step without saturated slope");

endmodule

bind dual_slope_phase_tracker_unit dspt_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dspt_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
